// ----- hw/rtl/ssc_pkg.sv -----
// Shared constants, payload types and table row type for the stepwise schedule cost block.
`default_nettype none

package ssc_pkg;

   // Sizing of the job attribute tables.
   localparam int MAX_JOBS   = 512;
   localparam int MAX_TARDY  = 9;
   localparam int MAX_EARLY  = 2;
   localparam int VALUE_BITS = 16;

   localparam int JOB_BITS  = $clog2(MAX_JOBS);
   localparam int NUM_WORDS = 1 + 2 * MAX_EARLY + 2 * MAX_TARDY;

   // Slot layout of one job's attribute row.
   localparam int SLOT_PROC        = 0;
   localparam int SLOT_EARLY_DL    = 1;
   localparam int SLOT_EARLY_COST  = 1 + MAX_EARLY;
   localparam int SLOT_TARDY_DL    = 1 + 2 * MAX_EARLY;
   localparam int SLOT_TARDY_WT    = 1 + 2 * MAX_EARLY + MAX_TARDY;

   // Fixed field widths.
   localparam int MODE_BITS  = 1;
   localparam int INDEX_BITS = 9;
   localparam int SLOT_BITS  = 5;
   localparam int WORD_BITS  = 16;
   localparam int TIME_BITS  = 25;
   localparam int COST_BITS  = 48;
   localparam int EARLY_LVL_BITS = 2;
   localparam int TARDY_LVL_BITS = 4;

   localparam int TIME_SUM_BITS = ((TIME_BITS > VALUE_BITS) ? TIME_BITS : VALUE_BITS) + 1;
   localparam int CMP_BITS      = (TIME_BITS > VALUE_BITS) ? TIME_BITS : VALUE_BITS;
   localparam int SUM_EXT_BITS  = COST_BITS + 1;

   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
   localparam logic [COST_BITS-1:0] COST_MAX = '1;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 8;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_EARLY_LEVELS = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARDY_LEVELS = CSR_INDEX_BITS'(1);

   localparam logic [EARLY_LVL_BITS-1:0] EARLY_LEVELS_RESET = EARLY_LVL_BITS'(2);
   localparam logic [TARDY_LVL_BITS-1:0] TARDY_LEVELS_RESET = TARDY_LVL_BITS'(9);

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_EVAL = 1'b1;

   typedef logic [VALUE_BITS-1:0] value_type;

   typedef struct packed {
      logic [MODE_BITS-1:0]  mode;
      logic [INDEX_BITS-1:0] job_index;
      logic [SLOT_BITS-1:0]  slot;
      logic [WORD_BITS-1:0]  value;
      logic                  last;
   } req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] job_cost;
      logic [COST_BITS-1:0] total_cost;
      logic [TIME_BITS-1:0] completion_time;
      logic                 last_out;
   } rsp_type;

   typedef struct packed {
      value_type                  proc;
      value_type [MAX_EARLY-1:0]  early_dl;
      value_type [MAX_EARLY-1:0]  early_cost;
      value_type [MAX_TARDY-1:0]  tardy_dl;
      value_type [MAX_TARDY-1:0]  tardy_wt;
   } row_type;

   typedef struct packed {
      logic [EARLY_LVL_BITS-1:0] early_levels;
      logic [TARDY_LVL_BITS-1:0] tardy_levels;
   } levels_type;

endpackage

`default_nettype wire

// ----- hw/rtl/ssc_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module ssc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/ssc_table.sv -----
// Job attribute table: one RAM per attribute word, all read together as one row.
`default_nettype none

module ssc_table (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [ssc_pkg::JOB_BITS-1:0]  wr_job,
   input  wire logic [ssc_pkg::SLOT_BITS-1:0] wr_slot,
   input  wire ssc_pkg::value_type            wr_data,
   input  wire logic                          rd_en,
   input  wire logic [ssc_pkg::JOB_BITS-1:0]  rd_job,
   output ssc_pkg::row_type                   row
);

   ssc_pkg::value_type rd_word [ssc_pkg::NUM_WORDS];

   for (genvar i = 0; i < ssc_pkg::NUM_WORDS; i++) begin : g_word
      logic sel;
      assign sel = wr_en && (32'(wr_slot) == i);

      ssc_ram #(
         .WIDTH (ssc_pkg::VALUE_BITS),
         .DEPTH (ssc_pkg::MAX_JOBS)
      ) u_ram (
         .clock   (clock),
         .wr_en   (sel),
         .wr_addr (wr_job),
         .wr_data (wr_data),
         .rd_en   (rd_en),
         .rd_addr (rd_job),
         .rd_data (rd_word[i])
      );
   end

   // Gather the words of the row by slot position.
   always_comb begin
      row.proc = rd_word[ssc_pkg::SLOT_PROC];
      for (int e = 0; e < ssc_pkg::MAX_EARLY; e++) begin
         row.early_dl[e]   = rd_word[ssc_pkg::SLOT_EARLY_DL + e];
         row.early_cost[e] = rd_word[ssc_pkg::SLOT_EARLY_COST + e];
      end
      for (int k = 0; k < ssc_pkg::MAX_TARDY; k++) begin
         row.tardy_dl[k] = rd_word[ssc_pkg::SLOT_TARDY_DL + k];
         row.tardy_wt[k] = rd_word[ssc_pkg::SLOT_TARDY_WT + k];
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/ssc_charge.sv -----
// Cost selection for one job: parallel deadline compares and a priority pick.
`default_nettype none

module ssc_charge (
   input  wire logic [ssc_pkg::TIME_BITS-1:0] completion,
   input  wire ssc_pkg::row_type              row,
   input  wire ssc_pkg::levels_type           levels,
   output ssc_pkg::value_type                 cost
);

   logic [ssc_pkg::CMP_BITS-1:0] c_ext;
   logic                         tardy_on;
   ssc_pkg::value_type           last_wt;

   assign c_ext = ssc_pkg::CMP_BITS'(completion);

   // The last weight in use; a level count above the table depth means the deepest one.
   always_comb begin
      last_wt = row.tardy_wt[ssc_pkg::MAX_TARDY-1];
      for (int k = 0; k < ssc_pkg::MAX_TARDY - 1; k++) begin
         if (32'(levels.tardy_levels) == k + 1) begin
            last_wt = row.tardy_wt[k];
         end
      end
   end

   assign tardy_on = (levels.tardy_levels != '0) &&
                     (c_ext > ssc_pkg::CMP_BITS'(row.tardy_dl[0]));

   // Later assignments win, so the loops run from the deepest level upwards.
   always_comb begin
      cost = '0;
      if (tardy_on) begin
         cost = last_wt;
         for (int k = ssc_pkg::MAX_TARDY - 1; k >= 1; k--) begin
            if ((32'(levels.tardy_levels) > k) &&
                (c_ext <= ssc_pkg::CMP_BITS'(row.tardy_dl[k]))) begin
               cost = row.tardy_wt[k-1];
            end
         end
      end
      for (int e = ssc_pkg::MAX_EARLY - 1; e >= 0; e--) begin
         if ((32'(levels.early_levels) > e) &&
             (c_ext <= ssc_pkg::CMP_BITS'(row.early_dl[e]))) begin
            cost = row.early_cost[e];
         end
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/stepwise_schedule_cost.sv -----
// Top level of the stepwise schedule cost block: table, charge pipeline and running total.
// An evaluate transaction passes the RAM output register (stage 1), the stage 2 registers and
// the result register; rsp_valid rises when its result reaches the result register.
// Throughput: one transaction per cycle while req_stall is low.
// Load transactions write the attribute RAMs at once and produce no result.
// Reset clears the pipeline, the completion time and the running total, and returns the level
// registers to two early and nine tardy levels; the attribute tables are not cleared.
`default_nettype none

module stepwise_schedule_cost (
   input  wire logic                               clock,
   input  wire logic                               reset,

   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire ssc_pkg::req_type                   req_data,

   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output ssc_pkg::rsp_type                        rsp_data,

   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [ssc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [ssc_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   // ------------------------------------------------------------------
   // Pipeline flow. Each stage moves on when the stage after it is empty
   // or is itself moving, so a waiting result does not block new work
   // while there are bubbles behind it.
   // ------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic out_free, s2_free, s1_free;
   logic accept, eval_accept, load_accept;
   logic job_ok;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s2_free  = !s2_valid_ff || out_free;
   assign s1_free  = !s1_valid_ff || s2_free;

   assign req_stall   = !s1_free;
   assign accept      = req_valid && !req_stall;
   assign eval_accept = accept && (req_data.mode == ssc_pkg::MODE_EVAL);
   assign load_accept = accept && (req_data.mode == ssc_pkg::MODE_LOAD);

   // Job indices beyond the table are ignored on load and charge nothing on evaluate.
   assign job_ok = 32'(req_data.job_index) < ssc_pkg::MAX_JOBS;

   assign s1_valid_in  = s1_free  ? eval_accept  : s1_valid_ff;
   assign s2_valid_in  = s2_free  ? s1_valid_ff  : s2_valid_ff;
   assign rsp_valid_in = out_free ? s2_valid_ff  : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ------------------------------------------------------------------
   // Configuration registers. Writes are always taken; only the low bits
   // of the data that a register holds are kept.
   // ------------------------------------------------------------------
   ssc_pkg::levels_type levels_ff, levels_in;

   assign csr_ready = 1'b1;

   always_comb begin
      levels_in = levels_ff;
      if (csr_valid) begin
         case (csr_index)
            ssc_pkg::CSR_EARLY_LEVELS: begin
               levels_in.early_levels = ssc_pkg::EARLY_LVL_BITS'(csr_data);
            end
            ssc_pkg::CSR_TARDY_LEVELS: begin
               levels_in.tardy_levels = ssc_pkg::TARDY_LVL_BITS'(csr_data);
            end
            default: begin
               levels_in = levels_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff.early_levels <= ssc_pkg::EARLY_LEVELS_RESET;
         levels_ff.tardy_levels <= ssc_pkg::TARDY_LEVELS_RESET;
      end else begin
         levels_ff <= levels_in;
      end
   end

   // ------------------------------------------------------------------
   // Attribute table. A load writes one word; an evaluate reads the whole
   // row of its job, and the RAM output register forms stage 1.
   // ------------------------------------------------------------------
   ssc_pkg::row_type row;

   ssc_table u_table (
      .clock   (clock),
      .wr_en   (load_accept && job_ok),
      .wr_job  (ssc_pkg::JOB_BITS'(req_data.job_index)),
      .wr_slot (req_data.slot),
      .wr_data (ssc_pkg::VALUE_BITS'(req_data.value)),
      .rd_en   (eval_accept),
      .rd_job  (ssc_pkg::JOB_BITS'(req_data.job_index)),
      .row     (row)
   );

   logic s1_last_ff, s1_job_ok_ff;

   always_ff @(posedge clock) begin
      if (eval_accept) begin
         s1_last_ff   <= req_data.last;
         s1_job_ok_ff <= job_ok;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: advance the completion time (saturating) and choose the
   // job's charge from its row.
   // ------------------------------------------------------------------
   logic [ssc_pkg::TIME_BITS-1:0]     elapsed_ff, elapsed_in;
   logic [ssc_pkg::TIME_SUM_BITS-1:0] time_sum;
   logic [ssc_pkg::TIME_BITS-1:0]     time_sat;
   logic [ssc_pkg::TIME_BITS-1:0]     completion;
   ssc_pkg::value_type                charge;
   logic                              s1_move;

   assign time_sum = ssc_pkg::TIME_SUM_BITS'(elapsed_ff) + ssc_pkg::TIME_SUM_BITS'(row.proc);
   assign time_sat = (time_sum > ssc_pkg::TIME_SUM_BITS'(ssc_pkg::TIME_MAX)) ?
                     ssc_pkg::TIME_MAX : ssc_pkg::TIME_BITS'(time_sum);
   assign completion = s1_job_ok_ff ? time_sat : elapsed_ff;

   ssc_charge u_charge (
      .completion (completion),
      .row        (row),
      .levels     (levels_ff),
      .cost       (charge)
   );

   assign s1_move = s1_valid_ff && s2_free;

   // The completion time restarts from zero after the job that ends a schedule.
   always_comb begin
      elapsed_in = elapsed_ff;
      if (s1_move) begin
         elapsed_in = s1_last_ff ? '0 : completion;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
      end else begin
         elapsed_ff <= elapsed_in;
      end
   end

   ssc_pkg::value_type            s2_cost_ff;
   logic [ssc_pkg::TIME_BITS-1:0] s2_time_ff;
   logic                          s2_last_ff;

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_cost_ff <= s1_job_ok_ff ? charge : '0;
         s2_time_ff <= completion;
         s2_last_ff <= s1_last_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: add the charge to the running total, saturating, and load
   // the result register.
   // ------------------------------------------------------------------
   logic [ssc_pkg::COST_BITS-1:0]    sum_ff, sum_in;
   logic [ssc_pkg::SUM_EXT_BITS-1:0] sum_ext;
   logic [ssc_pkg::COST_BITS-1:0]    sum_sat;
   logic                             s2_move;
   ssc_pkg::rsp_type                 rsp_ff;

   assign sum_ext = ssc_pkg::SUM_EXT_BITS'(sum_ff) + ssc_pkg::SUM_EXT_BITS'(s2_cost_ff);
   assign sum_sat = sum_ext[ssc_pkg::COST_BITS] ? ssc_pkg::COST_MAX
                                                : ssc_pkg::COST_BITS'(sum_ext);
   assign s2_move = s2_valid_ff && out_free;

   // The running total also restarts after the last job of a schedule.
   always_comb begin
      sum_in = sum_ff;
      if (s2_move) begin
         sum_in = s2_last_ff ? '0 : sum_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_move) begin
         rsp_ff.job_cost        <= ssc_pkg::WORD_BITS'(s2_cost_ff);
         rsp_ff.total_cost      <= sum_sat;
         rsp_ff.completion_time <= s2_time_ff;
         rsp_ff.last_out        <= s2_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire
